FILE: rtl/lksr_pkg.sv
package lksr_pkg;

  // field widths
  localparam int unsigned KEY_W        = 5;
  localparam int unsigned SAMPLE_W     = 10;
  localparam int unsigned HOLD_W       = 16;
  localparam int unsigned IDLE_W       = 8;
  localparam int unsigned CFG_IDX_W    = 2;
  localparam int unsigned CFG_DATA_W   = 16;

  // default depth of the scan queue between decode and state update
  localparam int unsigned QUEUE_DEPTH  = 2;

  // key codes
  localparam logic [KEY_W-1:0] KEY_RELEASED    = 5'd0;
  localparam logic [KEY_W-1:0] KEY_PINS_B_BASE = 5'd7;
  localparam logic [KEY_W-1:0] KEY_LADDER_BASE = 5'd15;
  localparam logic [KEY_W-1:0] KEY_LADDER_B    = 5'd19;
  localparam logic [KEY_W-1:0] KEY_VOL_UP      = 5'd17;
  localparam logic [KEY_W-1:0] KEY_VOL_DOWN    = 5'd18;

  // idle counter drain per tick
  localparam logic [IDLE_W-1:0] IDLE_STEP      = 8'd5;

  // register reset values
  localparam logic [IDLE_W-1:0] IDLE_RATE_RST  = 8'd0;
  localparam logic [HOLD_W-1:0] FIRST_DLY_RST  = 16'd3000;
  localparam logic [HOLD_W-1:0] REPEAT_INT_RST = 16'd700;
  localparam logic [HOLD_W-1:0] HOLD_MAX       = 16'hFFFF;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IDLE_RATE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_DLY  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_INT = 2'd2;

  typedef struct packed {
    logic [5:0]          button_pins_a;
    logic [3:0]          button_pins_b;
    logic [SAMPLE_W-1:0] ladder_sample_a;
    logic [SAMPLE_W-1:0] ladder_sample_b;
    logic                tick;
  } in_item_t;

  typedef struct packed {
    logic [KEY_W-1:0] key_number;
    logic             send_event;
  } out_item_t;

  // decoded scan as it travels through the queue
  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic             tick;
  } scan_t;

  // queue handshake toward the back part
  typedef struct packed {
    logic  valid;
    scan_t scan;
  } queue_out_t;

endpackage

FILE: rtl/lksr_front.sv
module lksr_front (
  input  logic                in_valid,
  input  lksr_pkg::in_item_t  in_data,
  input  logic                push_ready,
  output logic                in_ready,
  output logic                push_valid,
  output lksr_pkg::scan_t     push_scan
);

  // window of one ladder reading, 4 when outside all windows
  function automatic logic [2:0] ladder_window(input logic [lksr_pkg::SAMPLE_W-1:0] v);
    logic [2:0] w;
    w = 3'd4;
    if (v < 10'd10) begin
      w = 3'd0;
    end else if (v > 10'd200 && v < 10'd320) begin
      w = 3'd1;
    end else if (v > 10'd460 && v < 10'd600) begin
      w = 3'd2;
    end else if (v > 10'd700 && v < 10'd890) begin
      w = 3'd3;
    end
    return w;
  endfunction

  logic [2:0]                win_a;
  logic [2:0]                win_b;
  logic [lksr_pkg::KEY_W-1:0] key;

  assign win_a = ladder_window(in_data.ladder_sample_a);
  assign win_b = ladder_window(in_data.ladder_sample_b);

  // priority decode: pins a, pins b, ladder a, ladder b
  always_comb begin
    key = lksr_pkg::KEY_RELEASED;
    if (win_b != 3'd4) begin
      key = lksr_pkg::KEY_LADDER_B + {2'b00, win_b};
    end
    if (win_a != 3'd4) begin
      key = lksr_pkg::KEY_LADDER_BASE + {2'b00, win_a};
    end
    for (int i = 3; i >= 0; i--) begin
      if (!in_data.button_pins_b[i]) begin
        key = lksr_pkg::KEY_PINS_B_BASE + 5'(i);
      end
    end
    for (int i = 5; i >= 0; i--) begin
      if (!in_data.button_pins_a[i]) begin
        key = 5'(i + 1);
      end
    end
  end

  assign in_ready       = push_ready;
  assign push_valid     = in_valid;
  assign push_scan.key  = key;
  assign push_scan.tick = in_data.tick;

endmodule

FILE: rtl/lksr_queue.sv
module lksr_queue #(
  parameter int unsigned DEPTH = lksr_pkg::QUEUE_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push_valid,
  input  lksr_pkg::scan_t       push_scan,
  output logic                  push_ready,
  input  logic                  pop_ready,
  output lksr_pkg::queue_out_t  pop
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  lksr_pkg::scan_t  mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign push_ready = (count_r != CNT_FULL);
  assign pop.valid  = (count_r != '0);
  assign pop.scan   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop.valid && pop_ready;

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_scan;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_FULL)
    else $error("queue fill count above depth");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0 || count_r == CNT_FULL) |-> (wr_ptr_r == rd_ptr_r))
    else $error("queue pointers disagree with fill count");
`endif

endmodule

FILE: rtl/lksr_back.sv
module lksr_back (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  input  logic [lksr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lksr_pkg::CFG_DATA_W-1:0] cfg_data,
  input  lksr_pkg::queue_out_t            pop,
  output logic                            pop_ready,
  output logic                            out_valid,
  input  logic                            out_ready,
  output lksr_pkg::out_item_t             out_data
);

  logic [lksr_pkg::IDLE_W-1:0] idle_rate_r;
  logic [lksr_pkg::HOLD_W-1:0] first_dly_r;
  logic [lksr_pkg::HOLD_W-1:0] repeat_int_r;

  logic [lksr_pkg::KEY_W-1:0]  prev_key_r, prev_key_nxt;
  logic [lksr_pkg::HOLD_W-1:0] hold_r, hold_nxt;
  logic                        rep_done_r, rep_done_nxt;
  logic [lksr_pkg::IDLE_W-1:0] idle_r, idle_nxt;
  logic                        out_valid_r;
  lksr_pkg::out_item_t         out_data_r, out_data_nxt;

  logic                        take;
  logic [lksr_pkg::KEY_W-1:0]  key;
  logic [lksr_pkg::HOLD_W-1:0] limit;
  logic                        send;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idle_rate_r  <= lksr_pkg::IDLE_RATE_RST;
      first_dly_r  <= lksr_pkg::FIRST_DLY_RST;
      repeat_int_r <= lksr_pkg::REPEAT_INT_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        lksr_pkg::CFG_IDLE_RATE:  idle_rate_r  <= cfg_data[lksr_pkg::IDLE_W-1:0];
        lksr_pkg::CFG_FIRST_DLY:  first_dly_r  <= cfg_data;
        lksr_pkg::CFG_REPEAT_INT: repeat_int_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // take a scan whenever the output register is free or being drained
  assign pop_ready = !out_valid_r || out_ready;
  assign take      = pop.valid && pop_ready;
  assign key       = pop.scan.key;
  assign limit     = rep_done_r ? repeat_int_r : first_dly_r;

  // change detect, volume auto-repeat and idle resend
  always_comb begin
    prev_key_nxt = prev_key_r;
    hold_nxt     = hold_r;
    rep_done_nxt = rep_done_r;
    idle_nxt     = idle_r;
    send         = 1'b0;
    if (key != prev_key_r) begin
      prev_key_nxt = key;
      send         = 1'b1;
      hold_nxt     = '0;
      rep_done_nxt = 1'b0;
    end else if (key == lksr_pkg::KEY_VOL_UP || key == lksr_pkg::KEY_VOL_DOWN) begin
      if (hold_r > limit) begin
        send         = 1'b1;
        hold_nxt     = '0;
        rep_done_nxt = 1'b1;
      end else if (hold_r != lksr_pkg::HOLD_MAX) begin
        hold_nxt = hold_r + 1'b1;
      end
    end
    if (pop.scan.tick && idle_rate_r != '0 && key < lksr_pkg::KEY_LADDER_BASE) begin
      if (idle_r > 8'd4) begin
        idle_nxt = idle_r - lksr_pkg::IDLE_STEP;
      end else begin
        idle_nxt = idle_rate_r;
        send     = 1'b1;
      end
    end
    out_data_nxt.key_number = key;
    out_data_nxt.send_event = send;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_key_r  <= lksr_pkg::KEY_RELEASED;
      hold_r      <= '0;
      rep_done_r  <= 1'b0;
      idle_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (take) begin
        prev_key_r <= prev_key_nxt;
        hold_r     <= hold_nxt;
        rep_done_r <= rep_done_nxt;
        idle_r     <= idle_nxt;
      end
      if (take) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (take) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_hold_only_volume: assert property (@(posedge clk) disable iff (!rst_n)
    (hold_r != '0 || rep_done_r) |->
      (prev_key_r == lksr_pkg::KEY_VOL_UP || prev_key_r == lksr_pkg::KEY_VOL_DOWN))
    else $error("hold state kept for a key that does not repeat");

  a_change_sends: assert property (@(posedge clk) disable iff (!rst_n)
    (take && key != prev_key_r) |=> (out_valid_r && out_data_r.send_event))
    else $error("key change did not raise send_event");

  a_result_matches_key: assert property (@(posedge clk) disable iff (!rst_n)
    take |=> (out_data_r.key_number == prev_key_r))
    else $error("result key differs from stored key");
`endif

endmodule

FILE: rtl/ladder_keypad_scanner_with_repeat_core.sv
// Ladder keypad scanner with auto-repeat. Each input item is one scan: ten
// active-low button pins, two 10-bit ladder ADC samples and an idle tick. Every
// scan gives exactly one result: the decoded key (0 none, 1-10 buttons, 15-22
// ladder windows) and a send flag, raised on a key change, on auto-repeat of a
// held key 17 or 18 (once held past first_repeat_delay, then repeat_interval)
// and on idle resend of keys below 15 when idle_rate is nonzero. One scan is
// accepted per cycle while the queue has room; a scan passes the decode-side
// queue entry and the result register after the state update. A queue of
// QUEUE_DEPTH entries sits between decode and state update. Configuration
// writes are always accepted (cfg_ready is tied high); indexes 0..2 select
// idle_rate, first_repeat_delay and repeat_interval, index 3 is ignored.
module ladder_keypad_scanner_with_repeat_core #(
  parameter int unsigned QUEUE_DEPTH = lksr_pkg::QUEUE_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  lksr_pkg::in_item_t              in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output lksr_pkg::out_item_t             out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [lksr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lksr_pkg::CFG_DATA_W-1:0] cfg_data
);

  logic                 push_valid;
  logic                 push_ready;
  lksr_pkg::scan_t      push_scan;
  lksr_pkg::queue_out_t pop;
  logic                 pop_ready;

  assign cfg_ready = 1'b1;

  // key decode
  lksr_front u_front (
    .in_valid   (in_valid),
    .in_data    (in_data),
    .push_ready (push_ready),
    .in_ready   (in_ready),
    .push_valid (push_valid),
    .push_scan  (push_scan)
  );

  // decoded scan queue
  lksr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_scan  (push_scan),
    .push_ready (push_ready),
    .pop_ready  (pop_ready),
    .pop        (pop)
  );

  // key state, repeat and idle logic
  lksr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pop       (pop),
    .pop_ready (pop_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
